/* rtl/crackle_voronoi_noise_top_defines.svh */
// Assertion helpers for the crackle noise block.
// Both sample on clk and are off while rst_n is low.
`ifndef CRACKLE_VORONOI_NOISE_TOP_DEFINES_SVH
`define CRACKLE_VORONOI_NOISE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle.
`define CVN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cvn check failed");

// Consequent must hold in the next cycle.
`define CVN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cvn check failed");

`endif

/* rtl/cvn_pkg.sv */
package cvn_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CELL_W        = 32 - FRAC_BITS + 1;
  localparam int CACHE_POINTS  = 81;
  localparam int CACHE_IW      = $clog2(CACHE_POINTS);
  localparam logic [31:0] LCG_MUL      = 32'd17231723;
  localparam logic [31:0] LCG_INC      = 32'd2001;
  localparam logic [31:0] SHUFFLE_SEED = 32'd12345;
  localparam logic [31:0] CRACKLE_MAX  = 32'd524287;
  localparam logic signed [31:0] GRAD_LIMIT = 32'sd393216;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic [18:0]        crackle_value;
    logic signed [19:0] gradient_x;
    logic signed [19:0] gradient_y;
    logic signed [19:0] gradient_z;
  } out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } cache_ent_t;

  typedef enum logic [4:0] {
    S_FILL, S_SH_LCG, S_SH_RD, S_SH_W1, S_SH_W2,
    S_IDLE, S_HA, S_HB, S_HC, S_HD,
    S_NEXT, S_LCG, S_DRAW, S_WR,
    S_SRCH, S_SQX, S_SQY, S_SQZ, S_CMP,
    S_RT2, S_RW2, S_RT1, S_RW1, S_OUT
  } state_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    return s * LCG_MUL + LCG_INC;
  endfunction

  // round(r * 65536 / 32767); 65536 = 2*32767 + 2, so the fraction is a
  // pair of compares on 2r + 16383.
  function automatic logic [16:0] scale_draw(input logic [14:0] r);
    logic [16:0] t;
    logic [16:0] q;
    t = {1'b0, r, 1'b0} + 17'd16383;
    q = {1'b0, r, 1'b0};
    q = q + 17'(t >= 17'd32767) + 17'(t >= 17'd65534);
    return q;
  endfunction

  // floor((p - 1 LSB) / 2^FRAC_BITS)
  function automatic logic signed [CELL_W-1:0] cell_of(input logic [31:0] p);
    logic signed [32:0] q;
    q = $signed({p[31], p}) - 33'sd1;
    return q[32:FRAC_BITS];
  endfunction

  function automatic logic signed [19:0] grad_clamp(input logic [31:0] a,
                                                     input logic [31:0] b);
    logic signed [31:0] g;
    g = $signed(a - b);
    if (g > GRAD_LIMIT) g = GRAD_LIMIT;
    if (g < -GRAD_LIMIT) g = -GRAD_LIMIT;
    return g[19:0];
  endfunction

endpackage

/* rtl/cvn_isqrt.sv */
module cvn_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v_r, res_r, bit_r;
  logic        busy_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  // restoring square root: one root bit per step, two radicand bits consumed per step
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];
endmodule

/* rtl/crackle_voronoi_noise_top.sv */
// Crackle (cellular F2-F1) noise on a Q16.16 3D point, one request at a time.
// The cell hash is computed first; when it matches the cached one, the 81 cache
// entries go through the single squaring multiplier one axis at a time, then two
// 32-step square roots follow; otherwise the 81-point cache is rebuilt first. The
// next request is taken as soon as the result is in the output register.
// Reset: synchronous, active low; then the permutation table is filled and shuffled.
module crackle_voronoi_noise_top #(
  parameter int HASH_MASK = 4095
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cvn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cvn_pkg::out_t out_data
);
  import cvn_pkg::*;

  localparam int PERM_DEPTH = HASH_MASK + 1;
  localparam int AW = $clog2(PERM_DEPTH);
  localparam logic [AW-1:0] MASK = AW'(HASH_MASK);
  localparam logic [CACHE_IW-1:0] LAST_IDX = CACHE_IW'(CACHE_POINTS - 1);

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------
  // Permutation table: one write port, two registered read ports (the
  // second only serves the shuffle after reset).
  // ---------------------------------------------------------------------
  logic [AW-1:0] perm_mem [PERM_DEPTH];
  logic          perm_we;
  logic [AW-1:0] perm_waddr, perm_wdata, perm_raddr_a, perm_raddr_b;
  logic [AW-1:0] perm_rd_a_r, perm_rd_b_r;

  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
    perm_rd_a_r <= perm_mem[perm_raddr_a];
    perm_rd_b_r <= perm_mem[perm_raddr_b];
  end

  // ---------------------------------------------------------------------
  // Feature point cache: 81 entries of x/y/z, written at index n_r.
  // ---------------------------------------------------------------------
  cache_ent_t          cache_mem [CACHE_POINTS];
  logic                cache_we;
  cache_ent_t          cache_wdata;
  logic [CACHE_IW-1:0] cache_raddr;
  cache_ent_t          cache_rd_r;
  logic [CACHE_IW-1:0] n_r;

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[n_r] <= cache_wdata;
    cache_rd_r <= cache_mem[cache_raddr];
  end

  // ---------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------
  in_t                     pt_r;
  logic signed [CELL_W-1:0] cx_r, cy_r, cz_r;
  logic signed [2:0]       ox_r, oy_r, oz_r;
  logic                    rebuild_r;
  logic [31:0]             seed_r;
  logic [1:0]              draw_r;
  logic [16:0]             fx_r, fy_r, fz_r;
  logic [AW-1:0]           fill_r, pi_r, pj_r, tmp_r;
  logic [AW-1:0]           last_hash_r;
  logic                    cvalid_r;
  logic [63:0]             prod_r, acc_r, d1_r, d2_r;
  cache_ent_t              p1_r, p2_r;
  logic [31:0]             s1_r, s2_r;
  logic                    out_valid_r;
  out_t                    out_data_r;

  // cell of the current neighbor (offset applied)
  logic signed [CELL_W:0] hx, hy, hz;
  assign hx = {cx_r[CELL_W-1], cx_r} + {{(CELL_W-2){ox_r[2]}}, ox_r};
  assign hy = {cy_r[CELL_W-1], cy_r} + {{(CELL_W-2){oy_r[2]}}, oy_r};
  assign hz = {cz_r[CELL_W-1], cz_r} + {{(CELL_W-2){oz_r[2]}}, oz_r};

  // neighbor walk: z fastest, then y, then x
  logic signed [2:0] ox_adv, oy_adv, oz_adv;
  logic [1:0]        far_cnt;
  always_comb begin
    ox_adv = ox_r;
    oy_adv = oy_r;
    oz_adv = oz_r + 3'sd1;
    if (oz_r == 3'sd2) begin
      oz_adv = -3'sd2;
      oy_adv = oy_r + 3'sd1;
      if (oy_r == 3'sd2) begin
        oy_adv = -3'sd2;
        ox_adv = ox_r + 3'sd1;
      end
    end
    far_cnt = 2'(ox_r == 3'sd2 || ox_r == -3'sd2) + 2'(oy_r == 3'sd2 || oy_r == -3'sd2)
            + 2'(oz_r == 3'sd2 || oz_r == -3'sd2);
  end

  // single squaring multiplier, one axis per cycle
  logic [31:0]        dsel;
  logic signed [63:0] sq;
  logic [63:0]        dist_sum;
  always_comb begin
    case (state_r)
      S_SQY:   dsel = cache_rd_r.y - pt_r.point_y;
      S_SQZ:   dsel = cache_rd_r.z - pt_r.point_z;
      default: dsel = cache_rd_r.x - pt_r.point_x;
    endcase
    sq       = $signed(dsel) * $signed(dsel);
    dist_sum = acc_r + prod_r;
  end

  // square root unit, shared by F2 and F1
  logic        sqrt_start, sqrt_busy;
  logic [31:0] sqrt_root;
  logic [63:0] sqrt_val;
  assign sqrt_val = (state_r == S_RT2) ? d2_r : d1_r;

  cvn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (sqrt_val),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  logic        in_acc, out_load;
  logic [16:0] fdraw;
  assign in_acc = in_valid && !in_stall;
  assign fdraw  = scale_draw(seed_r[30:16]);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    perm_we      = 1'b0;
    perm_waddr   = pi_r;
    perm_wdata   = tmp_r;
    perm_raddr_a = pi_r;
    perm_raddr_b = pj_r;
    cache_we     = 1'b0;
    cache_raddr  = n_r;
    sqrt_start   = 1'b0;
    out_load     = 1'b0;
    cache_wdata.x = {hx[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}} + 32'(fx_r);
    cache_wdata.y = {hy[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}} + 32'(fy_r);
    cache_wdata.z = {hz[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}} + 32'(fz_r);
    unique case (state_r)
      S_FILL: begin
        perm_we    = 1'b1;
        perm_waddr = fill_r;
        perm_wdata = fill_r;
        if (fill_r == MASK) state_nxt = S_SH_LCG;
      end
      S_SH_LCG: state_nxt = S_SH_RD;
      S_SH_RD: begin
        perm_raddr_b = AW'(seed_r[30:16]) & MASK;
        state_nxt    = S_SH_W1;
      end
      S_SH_W1: begin
        perm_we    = 1'b1;
        perm_waddr = pj_r;
        perm_wdata = perm_rd_a_r;
        state_nxt  = S_SH_W2;
      end
      S_SH_W2: begin
        perm_we   = 1'b1;
        state_nxt = (pi_r == MASK) ? S_IDLE : S_SH_LCG;
      end
      S_IDLE: if (in_acc) state_nxt = S_HA;
      S_HA: begin
        perm_raddr_a = hx[AW-1:0] & MASK;
        state_nxt    = S_HB;
      end
      S_HB: begin
        perm_raddr_a = (perm_rd_a_r ^ hy[AW-1:0]) & MASK;
        state_nxt    = S_HC;
      end
      S_HC: begin
        perm_raddr_a = (perm_rd_a_r ^ hz[AW-1:0]) & MASK;
        state_nxt    = S_HD;
      end
      S_HD: begin
        if (rebuild_r) state_nxt = S_LCG;
        else if (!cvalid_r || perm_rd_a_r != last_hash_r) state_nxt = S_NEXT;
        else state_nxt = S_SRCH;
      end
      S_NEXT: if (far_cnt <= 2'd1) state_nxt = S_HA;
      S_LCG:  state_nxt = S_DRAW;
      S_DRAW: if (draw_r == 2'd2) state_nxt = S_WR; else state_nxt = S_LCG;
      S_WR: begin
        cache_we  = 1'b1;
        state_nxt = (n_r == LAST_IDX) ? S_SRCH : S_NEXT;
      end
      S_SRCH: begin
        cache_raddr = '0;
        state_nxt   = S_SQX;
      end
      S_SQX: state_nxt = S_SQY;
      S_SQY: state_nxt = S_SQZ;
      S_SQZ: state_nxt = S_CMP;
      S_CMP: begin
        if (n_r == LAST_IDX) begin
          state_nxt = S_RT2;
        end else begin
          cache_raddr = n_r + 1'b1;
          state_nxt   = S_SQX;
        end
      end
      S_RT2: begin
        sqrt_start = 1'b1;
        state_nxt  = S_RW2;
      end
      S_RW2: if (!sqrt_busy) state_nxt = S_RT1;
      S_RT1: begin
        sqrt_start = 1'b1;
        state_nxt  = S_RW1;
      end
      S_RW1: if (!sqrt_busy) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pi_r        <= '0;
      cvalid_r    <= 1'b0;
      last_hash_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FILL) fill_r <= fill_r + 1'b1;
      if (state_r == S_SH_W2) pi_r <= pi_r + 1'b1;
      if (state_r == S_HD && !rebuild_r &&
          (!cvalid_r || perm_rd_a_r != last_hash_r)) begin
        cvalid_r    <= 1'b1;
        last_hash_r <= perm_rd_a_r;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r) inside
      S_FILL: seed_r <= SHUFFLE_SEED;
      S_SH_LCG, S_LCG: seed_r <= lcg_next(seed_r);
      S_SH_RD: pj_r <= AW'(seed_r[30:16]) & MASK;
      S_SH_W1: tmp_r <= perm_rd_b_r;
      S_IDLE: begin
        if (in_acc) begin
          pt_r      <= in_data;
          cx_r      <= cell_of(in_data.point_x);
          cy_r      <= cell_of(in_data.point_y);
          cz_r      <= cell_of(in_data.point_z);
          ox_r      <= '0;
          oy_r      <= '0;
          oz_r      <= '0;
          rebuild_r <= 1'b0;
        end
      end
      S_HD: begin
        if (rebuild_r) begin
          seed_r <= 32'(perm_rd_a_r);
          draw_r <= '0;
        end else begin
          ox_r      <= -3'sd2;
          oy_r      <= -3'sd2;
          oz_r      <= -3'sd2;
          n_r       <= '0;
          rebuild_r <= 1'b1;
        end
      end
      S_NEXT: begin
        if (far_cnt > 2'd1) begin
          ox_r <= ox_adv;
          oy_r <= oy_adv;
          oz_r <= oz_adv;
        end
      end
      S_DRAW: begin
        case (draw_r)
          2'd0:    fx_r <= fdraw;
          2'd1:    fy_r <= fdraw;
          default: fz_r <= fdraw;
        endcase
        draw_r <= draw_r + 2'd1;
      end
      S_WR: begin
        if (n_r != LAST_IDX) begin
          n_r  <= n_r + 1'b1;
          ox_r <= ox_adv;
          oy_r <= oy_adv;
          oz_r <= oz_adv;
        end
      end
      S_SRCH: begin
        n_r  <= '0;
        d1_r <= '1;
        d2_r <= '1;
      end
      S_SQX: prod_r <= 64'(sq);
      S_SQY: begin
        prod_r <= 64'(sq);
        acc_r  <= prod_r;
      end
      S_SQZ: begin
        prod_r <= 64'(sq);
        acc_r  <= acc_r + prod_r;
      end
      S_CMP: begin
        // strict compares: ties keep the earlier entry
        if (dist_sum < d1_r) begin
          d2_r <= d1_r;
          p2_r <= p1_r;
          d1_r <= dist_sum;
          p1_r <= cache_rd_r;
        end else if (dist_sum < d2_r) begin
          d2_r <= dist_sum;
          p2_r <= cache_rd_r;
        end
        if (n_r != LAST_IDX) n_r <= n_r + 1'b1;
      end
      S_RW2: if (!sqrt_busy) s2_r <= sqrt_root;
      S_RW1: if (!sqrt_busy) s1_r <= sqrt_root;
      default: ;
    endcase
  end

  // output register
  logic [31:0] val;
  assign val = s2_r - s1_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.crackle_value <= (val > CRACKLE_MAX) ? CRACKLE_MAX[18:0] : val[18:0];
      out_data_r.gradient_x    <= grad_clamp(p2_r.x, p1_r.x);
      out_data_r.gradient_y    <= grad_clamp(p2_r.y, p1_r.y);
      out_data_r.gradient_z    <= grad_clamp(p2_r.z, p1_r.z);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

/* rtl/cvn_checker.sv */
`include "crackle_voronoi_noise_top_defines.svh"

module cvn_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input cvn_pkg::out_t out_data
);
  import cvn_pkg::*;

  `CVN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `CVN_ASSERT_SAME(a_grad_range, out_valid, out_data.gradient_x <= 20'sd393216 && out_data.gradient_x >= -20'sd393216 && out_data.gradient_y <= 20'sd393216 && out_data.gradient_y >= -20'sd393216 && out_data.gradient_z <= 20'sd393216 && out_data.gradient_z >= -20'sd393216)

  `CVN_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
endmodule

bind crackle_voronoi_noise_top cvn_checker u_cvn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/crackle_checker.sv */
module crackle_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  cvn_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  cvn_pkg::out_t out_data,
  output int            errors,
  output int            pending,
  output int            requests,
  output int            rebuilds
);
  timeunit 1ns;
  timeprecision 1ps;
  import cvn_pkg::*;

  localparam int TABLE_SIZE = 4096;
  localparam int NPTS = 81;
  localparam longint SAT_VAL = 524287;
  localparam longint SAT_GRAD = 393216;

  logic [11:0] perm_tbl [TABLE_SIZE];
  logic [31:0] pt_x [NPTS];
  logic [31:0] pt_y [NPTS];
  logic [31:0] pt_z [NPTS];
  logic [11:0] cached_hash;
  bit          cache_live;
  out_t        expected_crackle [$];

  function automatic logic [14:0] next_draw(inout logic [31:0] s);
    s = s * 32'd17231723 + 32'd2001;
    return s[30:16];
  endfunction

  function automatic logic [31:0] frac_of(input logic [14:0] r);
    logic [63:0] num;
    num = ({49'd0, r} << 16) + 64'd16383;
    return 32'(num / 64'd32767);
  endfunction

  function automatic logic [11:0] hash_of(input longint cx, input longint cy, input longint cz);
    logic [11:0] a;
    logic [11:0] b;
    a = perm_tbl[cx[11:0]];
    b = perm_tbl[a ^ cy[11:0]];
    return perm_tbl[b ^ cz[11:0]];
  endfunction

  function automatic logic [63:0] dist_sq(input int i, input in_t p);
    longint dx, dy, dz;
    dx = longint'($signed(pt_x[i] - p.point_x));
    dy = longint'($signed(pt_y[i] - p.point_y));
    dz = longint'($signed(pt_z[i] - p.point_z));
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  function automatic logic [63:0] root_of(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [19:0] grad_of(input logic [31:0] a, input logic [31:0] b);
    longint g;
    g = longint'($signed(a - b));
    if (g > SAT_GRAD) g = SAT_GRAD;
    if (g < -SAT_GRAD) g = -SAT_GRAD;
    return g[19:0];
  endfunction

  function automatic out_t crackle_predict(input in_t p);
    longint cx, cy, cz, v;
    logic [11:0] h;
    logic [31:0] seed;
    logic [63:0] d, d1, d2, val;
    int n, far, n1, n2;
    out_t r;
    cx = (longint'(p.point_x) - 1) >>> 16;
    cy = (longint'(p.point_y) - 1) >>> 16;
    cz = (longint'(p.point_z) - 1) >>> 16;
    h = hash_of(cx, cy, cz);
    if (!cache_live || h != cached_hash) begin
      n = 0;
      for (int ox = -2; ox <= 2; ox++)
        for (int oy = -2; oy <= 2; oy++)
          for (int oz = -2; oz <= 2; oz++) begin
            far = int'(ox == 2 || ox == -2) + int'(oy == 2 || oy == -2)
                + int'(oz == 2 || oz == -2);
            if (far <= 1 && n < NPTS) begin
              seed = 32'(hash_of(cx + ox, cy + oy, cz + oz));
              v = (cx + ox) << 16;
              pt_x[n] = 32'(v) + frac_of(next_draw(seed));
              v = (cy + oy) << 16;
              pt_y[n] = 32'(v) + frac_of(next_draw(seed));
              v = (cz + oz) << 16;
              pt_z[n] = 32'(v) + frac_of(next_draw(seed));
              n++;
            end
          end
      cached_hash = h;
      cache_live = 1;
      rebuilds++;
    end
    d1 = dist_sq(0, p);
    d2 = dist_sq(1, p);
    n1 = 0;
    n2 = 1;
    if (d1 > d2) begin
      d = d1; d1 = d2; d2 = d;
      n1 = 1; n2 = 0;
    end
    for (int i = 2; i < NPTS; i++) begin
      d = dist_sq(i, p);
      if (d < d1) begin
        d2 = d1; n2 = n1;
        d1 = d; n1 = i;
      end else if (d < d2) begin
        d2 = d; n2 = i;
      end
    end
    val = root_of(d2) - root_of(d1);
    if (val > SAT_VAL) val = SAT_VAL;
    r.crackle_value = val[18:0];
    r.gradient_x = grad_of(pt_x[n2], pt_x[n1]);
    r.gradient_y = grad_of(pt_y[n2], pt_y[n1]);
    r.gradient_z = grad_of(pt_z[n2], pt_z[n1]);
    return r;
  endfunction

  initial begin
    logic [31:0] s;
    logic [11:0] j, t;
    s = 32'd12345;
    for (int i = 0; i < TABLE_SIZE; i++) perm_tbl[i] = 12'(i);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      j = 12'(next_draw(s));
      t = perm_tbl[j];
      perm_tbl[j] = perm_tbl[i];
      perm_tbl[i] = t;
    end
    cache_live = 0;
    cached_hash = 0;
    errors = 0;
    requests = 0;
    rebuilds = 0;
  end

  assign pending = expected_crackle.size();

  always @(posedge clk) begin
    out_t e;
    if (rst_n && in_valid && !in_stall) begin
      expected_crackle.push_back(crackle_predict(in_data));
      requests++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_crackle.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_crackle.pop_front();
        if (e.crackle_value !== out_data.crackle_value) begin
          $display("%0t: crackle_value exp %0d got %0d", $time,
                   e.crackle_value, out_data.crackle_value);
          errors++;
        end
        if (e.gradient_x !== out_data.gradient_x) begin
          $display("%0t: gradient_x exp %0d got %0d", $time, e.gradient_x, out_data.gradient_x);
          errors++;
        end
        if (e.gradient_y !== out_data.gradient_y) begin
          $display("%0t: gradient_y exp %0d got %0d", $time, e.gradient_y, out_data.gradient_y);
          errors++;
        end
        if (e.gradient_z !== out_data.gradient_z) begin
          $display("%0t: gradient_z exp %0d got %0d", $time, e.gradient_z, out_data.gradient_z);
          errors++;
        end
      end
    end
  end
endmodule

/* tb/crackle_voronoi_noise_top_tb.sv */
module crackle_voronoi_noise_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvn_pkg::*;

  logic  clk = 0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  int    errors, pending, requests, rebuilds;
  int    results_seen;
  bit    no_gaps;      // when set, neither side idles
  bit    long_hold;    // asks the receiver for one long hold-off

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  crackle_voronoi_noise_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  crackle_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending), .requests(requests), .rebuilds(rebuilds)
  );

  // Idle draw for either side: random, and none during quiet stretches.
  function automatic int gap_draw();
    return no_gaps ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Offer one request; returns at the falling edge after it is taken.
  // Valid stays high straight into the next request when no gap is drawn.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    int g;
    g = gap_draw();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_data.point_x = x;
    in_data.point_y = y;
    in_data.point_z = z;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Point inside cell c: floor((p-1)/2^16) == c means p in (c*2^16, c*2^16 + 2^16].
  function automatic logic [31:0] in_cell(input logic [31:0] c);
    return (c << 16) + 32'($urandom_range(1, 65536));
  endfunction

  // Receiver: random stall per result, with one long hold-off when asked.
  initial begin
    int g;
    out_stall = 0;
    results_seen = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1;
        repeat (6000) @(negedge clk);  // block fills, input must stall
        long_hold = 0;
      end
      g = gap_draw();
      if (g > 0) begin
        out_stall = 1;
        repeat (g) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  // Watchdog: reports failure and stops if the run has not finished.
  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] cx, cy, cz;
    int burst, kind;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    no_gaps = 0;
    long_hold = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed: zero, LSB steps around cell edges, both coordinate extremes
    // (cell corners wrap), and repeats in the same cell to reuse the cache.
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h1, 32'h1, 32'h1);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_point(32'h10000, 32'h10000, 32'h10000);
    send_point(32'h10001, 32'h10000, 32'h0ffff);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000001, 32'h7fffffff, 32'h0);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000001);
    send_point(32'h00008000, 32'h00008000, 32'h00008000);
    send_point(32'h00004000, 32'h0000c000, 32'h00002000);
    send_point(32'h0000f000, 32'h00000800, 32'h00010000);
    send_point(32'hfff08000, 32'h00128000, 32'hffff0001);
    send_point(32'hfff08001, 32'h00127fff, 32'hffff0002);
    send_point(32'h55555555, 32'haaaaaaaa, 32'h33333333);
    send_point(32'haaaaaaaa, 32'h55555555, 32'hcccccccc);

    // Random: mostly bursts inside one cell (cache hits), sometimes a step to
    // a neighbor, plus scattered full-range points that force rebuilds.
    for (int i = 0; i < 1100; ) begin
      if (i >= 300 && i < 420) no_gaps = 1;
      else no_gaps = 0;
      if (i >= 600 && i < 604) long_hold = 1;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_point($urandom, $urandom, $urandom);
        i++;
      end else begin
        if (kind < 7) begin
          cx = 32'($signed($urandom_range(0, 64)) - 32);
          cy = 32'($signed($urandom_range(0, 64)) - 32);
          cz = 32'($signed($urandom_range(0, 64)) - 32);
        end else begin
          cx = $urandom; cy = $urandom; cz = $urandom;
        end
        burst = $urandom_range(2, 8);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 7) == 0) cx = cx + ($urandom_range(0, 1) ? 1 : -1);
          send_point(in_cell(cx), in_cell(cy), in_cell(cz));
          i++;
        end
      end
    end
    in_valid = 0;

    wait (pending == 0);
    repeat (2000) @(negedge clk);
    $display("Ran %0d requests (%0d results checked), %0d cache rebuilds,", requests,
             results_seen, rebuilds);
    $display("covering cell edges, coordinate wraparound, cache reuse and stalls.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/cvn_pkg.sv
rtl/cvn_isqrt.sv
rtl/crackle_voronoi_noise_top.sv
rtl/cvn_checker.sv
tb/crackle_checker.sv
tb/crackle_voronoi_noise_top_tb.sv
